### src/lut3d_color_mapper_assert.svh
// Assertion macros for the 3D LUT color mapper.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef LUT3D_COLOR_MAPPER_ASSERT_SVH
`define LUT3D_COLOR_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS
`define L3D_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("l3d assertion failed");
`define L3D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("l3d assertion failed");
`else
`define L3D_ASSERT_SAME(lbl, ante, cons)
`define L3D_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/l3d_pkg.sv
// Shared types and constants of the 3D LUT color mapper.
// No dependencies.
`timescale 1ns / 1ps

package l3d_pkg;

  localparam int unsigned MAX_POINTS_DEF   = 17;
  localparam int unsigned CHANNEL_BITS_DEF = 16;
  localparam int unsigned GRID_BITS        = 5;
  localparam int unsigned PIX_BITS         = 16;
  localparam int unsigned IDX_BITS         = 13;

  localparam logic [GRID_BITS-1:0] GRID_RESET = 5'd17;

  localparam logic CMD_APPLY = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic                command;
    logic [PIX_BITS-1:0] red_in;
    logic [PIX_BITS-1:0] green_in;
    logic [PIX_BITS-1:0] blue_in;
    logic [IDX_BITS-1:0] entry_index;
  } l3d_pix_in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] red_out;
    logic [PIX_BITS-1:0] green_out;
    logic [PIX_BITS-1:0] blue_out;
  } l3d_pix_out_t;

  typedef struct packed {
    logic prod;
    logic split;
  } l3d_scale_en_t;

  typedef struct packed {
    logic mul;
    logic sum;
    logic fold;
  } l3d_blend_en_t;

endpackage

### src/l3d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module l3d_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4913,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/l3d_scale_lane.sv
// One channel lane: scales a channel to a lattice position, splits it into
// floor, ceil and remainder. Depends on l3d_pkg.
`timescale 1ns / 1ps

module l3d_scale_lane #(
  parameter int unsigned MAX_POINTS   = l3d_pkg::MAX_POINTS_DEF,
  parameter int unsigned CHANNEL_BITS = l3d_pkg::CHANNEL_BITS_DEF,
  localparam int unsigned LW          = $clog2(MAX_POINTS)
) (
  input  logic                        clk_i,
  input  l3d_pkg::l3d_scale_en_t      en_i,
  input  logic [l3d_pkg::PIX_BITS-1:0] chan_i,
  input  logic [LW-1:0]               nm1_i,
  output logic [LW-1:0]               lo_o,
  output logic [LW-1:0]               hi_o,
  output logic [CHANNEL_BITS-1:0]     rem_o
);

  import l3d_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned PW = CB + LW;
  localparam logic [CB-1:0] FS = {CB{1'b1}};

  logic [CB-1:0] chan_sat;
  logic [PW-1:0] prod_q;
  logic [LW-1:0] q0;
  logic [CB:0]   r0;
  logic [CB:0]   r_sub;
  logic          wrap;
  logic [LW-1:0] lo_d, lo_q;
  logic [LW-1:0] hi_d, hi_q;
  logic [CB-1:0] rem_d, rem_q;

  always_comb begin
    chan_sat = (chan_i > PIX_BITS'(FS)) ? FS : chan_i[CB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= PW'(chan_sat) * PW'(nm1_i);
    end
  end

  always_comb begin
    q0    = prod_q[PW-1:CB];
    r0    = {1'b0, prod_q[CB-1:0]} + (CB+1)'(q0);
    wrap  = r0 >= {1'b0, FS};
    r_sub = r0 - {1'b0, FS};
    lo_d  = q0 + LW'(wrap);
    rem_d = wrap ? r_sub[CB-1:0] : r0[CB-1:0];
    hi_d  = lo_d + LW'(rem_d != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.split) begin
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      rem_q <= rem_d;
    end
  end

  assign lo_o  = lo_q;
  assign hi_o  = hi_q;
  assign rem_o = rem_q;

endmodule

### src/l3d_blend_lane.sv
// One channel lane: blends floor and ceil entries by the remainder, rounds
// to nearest and saturates. Depends on l3d_pkg.
`timescale 1ns / 1ps

module l3d_blend_lane #(
  parameter int unsigned CHANNEL_BITS = l3d_pkg::CHANNEL_BITS_DEF
) (
  input  logic                         clk_i,
  input  l3d_pkg::l3d_blend_en_t       en_i,
  input  logic [l3d_pkg::PIX_BITS-1:0] lo_i,
  input  logic [l3d_pkg::PIX_BITS-1:0] hi_i,
  input  logic [CHANNEL_BITS-1:0]      rem_i,
  output logic [l3d_pkg::PIX_BITS-1:0] res_o
);

  import l3d_pkg::*;

  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned LFW = PIX_BITS + CB;
  localparam int unsigned SW  = LFW + 2;
  localparam int unsigned YW  = LFW + 1;
  localparam int unsigned QW  = YW - CB;
  localparam int unsigned RW  = 18;
  localparam logic [YW-1:0] HALF = YW'((1 << (CB - 1)) - 1);
  localparam logic [RW-1:0] FS_R = RW'({CB{1'b1}});

  logic        [LFW-1:0]    lofs_q;
  logic signed [PIX_BITS:0] diff;
  logic signed [CB:0]       rem_s;
  logic signed [SW-1:0]     prod_q;
  logic signed [SW-1:0]     num;
  logic        [YW-1:0]     y_d, y_q;
  logic        [QW-1:0]     q0;
  logic        [RW-1:0]     r0, q1, r1, q2, r2, quo;
  logic                     wrap;
  logic [CB-1:0]            sat;
  logic [PIX_BITS-1:0]      res_q;

  always_comb begin
    diff  = $signed({1'b0, hi_i}) - $signed({1'b0, lo_i});
    rem_s = $signed({1'b0, rem_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      lofs_q <= (LFW'(lo_i) << CB) - LFW'(lo_i);
      prod_q <= diff * rem_s;
    end
  end

  always_comb begin
    num = $signed({2'b00, lofs_q}) + prod_q;
    y_d = (num < 0) ? HALF : (YW'(num[LFW-1:0]) + HALF);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      y_q <= y_d;
    end
  end

  // y / FS by folding the high part onto the low part
  always_comb begin
    q0   = y_q[YW-1:CB];
    r0   = RW'(y_q[CB-1:0]) + RW'(q0);
    q1   = r0 >> CB;
    r1   = (r0 & FS_R) + q1;
    q2   = r1 >> CB;
    r2   = (r1 & FS_R) + q2;
    wrap = r2 >= FS_R;
    quo  = RW'(q0) + q1 + q2 + RW'(wrap);
    sat  = (quo > FS_R) ? FS_R[CB-1:0] : quo[CB-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fold) begin
      res_q <= PIX_BITS'(sat);
    end
  end

  assign res_o = res_q;

endmodule

### src/lut3d_color_mapper.sv
// 3D LUT color mapper top level: handshake pipeline, index merge, table RAMs.
// Depends on l3d_pkg, l3d_ram, l3d_scale_lane, l3d_blend_lane and the
// assertion header.
//
// Usage: in_data_i carries one transaction per accept (in_valid_i & in_ready_o).
// A write command stores {red, green, blue} at entry_index and gives no result;
// an apply command maps the pixel and gives one result on out_data_o.
// cfg_data_i sets the lattice points per side; cfg_ready_o is always high;
// write it only while the pipeline is empty.
// Throughput: one transaction per cycle unless stalled; the table is read at the
// floor and ceil corners in the same cycle by two RAM copies written in parallel.
// Stall: each of the 8 stages holds its contents while the stage after it is
// full and not moving; bubbles collapse, so input stays open until every
// stage is full behind a stalled output.
// Reset: clears stage valids and sets points per side to 17; table contents
// stay undefined until written.
`timescale 1ns / 1ps

module lut3d_color_mapper #(
  parameter int unsigned MAX_POINTS   = l3d_pkg::MAX_POINTS_DEF,
  parameter int unsigned CHANNEL_BITS = l3d_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [l3d_pkg::GRID_BITS-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  l3d_pkg::l3d_pix_in_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output l3d_pkg::l3d_pix_out_t         out_data_o
);

  import l3d_pkg::*;

  localparam int unsigned CB    = CHANNEL_BITS;
  localparam int unsigned LW    = $clog2(MAX_POINTS);
  localparam int unsigned NW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned DEPTH = MAX_POINTS * MAX_POINTS * MAX_POINTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SUMW  = LW + 2 * NW + 1;
  localparam int unsigned EW    = (AW > IDX_BITS) ? AW : IDX_BITS;
  localparam int unsigned CMPW  = (NW > GRID_BITS) ? NW : GRID_BITS;
  localparam int unsigned ENTW  = 3 * PIX_BITS;
  localparam int unsigned NSTG  = 8;
  localparam int unsigned NCH   = 3;

  logic [GRID_BITS-1:0] grid_q;
  logic [CMPW-1:0]      grid_ext;
  logic [NW-1:0]        n_eff;
  logic [NW-1:0]        n_q;
  logic [LW-1:0]        nm1_q;
  logic [2*NW-1:0]      nsq_q;

  logic [NSTG-1:0] stg_v_q, stg_v_d, rdy;
  l3d_pix_in_t     pay_q [4];

  logic [PIX_BITS-1:0] chan   [NCH];
  logic [LW-1:0]       lo_w   [NCH];
  logic [LW-1:0]       hi_w   [NCH];
  logic [CB-1:0]       rem_w  [NCH];
  logic [CB-1:0]       rem3_q [NCH];
  logic [CB-1:0]       rem4_q [NCH];
  logic [PIX_BITS-1:0] res_w  [NCH];

  logic [LW-1:0]      lo0_q, hi0_q;
  logic [LW+NW-1:0]   plo1_q, phi1_q;
  logic [LW+2*NW-1:0] plo2_q, phi2_q;
  logic [SUMW-1:0]    sum_lo, sum_hi;
  logic [AW-1:0]      rd_lo, rd_hi;
  logic [EW-1:0]      widx;
  logic               wr_ok;
  logic               ram_we;
  logic [ENTW-1:0]    ram_wdata, ent_lo, ent_hi;

  l3d_scale_en_t scale_en;
  l3d_blend_en_t blend_en;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      grid_q <= cfg_data_i;
    end
  end

  always_comb begin
    grid_ext = CMPW'(grid_q);
    if (grid_ext < CMPW'(2)) begin
      n_eff = NW'(2);
    end else if (grid_ext > CMPW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = grid_ext[NW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_eff;
    nm1_q <= LW'(n_eff - NW'(1));
    nsq_q <= (2*NW)'(n_eff) * (2*NW)'(n_eff);
  end

  // stage handshake
  always_comb begin
    rdy[NSTG-1] = !stg_v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !stg_v_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    stg_v_d[0] = in_valid_i;
    for (int k = 1; k < NSTG; k++) begin
      stg_v_d[k] = stg_v_q[k-1];
    end
    stg_v_d[4] = stg_v_q[3] && (pay_q[3].command == CMD_APPLY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          stg_v_q[k] <= stg_v_d[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = stg_v_q[NSTG-1];

  // transaction payload through the first four stages
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pay_q[0] <= in_data_i;
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        pay_q[k] <= pay_q[k-1];
      end
    end
  end

  // scale lanes
  always_comb begin
    chan[0] = pay_q[0].red_in;
    chan[1] = pay_q[0].green_in;
    chan[2] = pay_q[0].blue_in;
    scale_en.prod  = rdy[1];
    scale_en.split = rdy[2];
    blend_en.mul   = rdy[5];
    blend_en.sum   = rdy[6];
    blend_en.fold  = rdy[7];
  end

  for (genvar g = 0; g < NCH; g++) begin : g_scale
    l3d_scale_lane #(
      .MAX_POINTS  (MAX_POINTS),
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_scale (
      .clk_i (clk_i),
      .en_i  (scale_en),
      .chan_i(chan[g]),
      .nm1_i (nm1_q),
      .lo_o  (lo_w[g]),
      .hi_o  (hi_w[g]),
      .rem_o (rem_w[g])
    );
  end

  // index merge: partial products, then sums
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      lo0_q  <= lo_w[0];
      hi0_q  <= hi_w[0];
      plo1_q <= (LW+NW)'(lo_w[1]) * (LW+NW)'(n_q);
      phi1_q <= (LW+NW)'(hi_w[1]) * (LW+NW)'(n_q);
      plo2_q <= (LW+2*NW)'(lo_w[2]) * (LW+2*NW)'(nsq_q);
      phi2_q <= (LW+2*NW)'(hi_w[2]) * (LW+2*NW)'(nsq_q);
      for (int k = 0; k < NCH; k++) begin
        rem3_q[k] <= rem_w[k];
      end
    end
    if (rdy[4]) begin
      for (int k = 0; k < NCH; k++) begin
        rem4_q[k] <= rem3_q[k];
      end
    end
  end

  always_comb begin
    sum_lo = SUMW'(lo0_q) + SUMW'(plo1_q) + SUMW'(plo2_q);
    sum_hi = SUMW'(hi0_q) + SUMW'(phi1_q) + SUMW'(phi2_q);
    rd_lo  = (sum_lo < SUMW'(DEPTH)) ? sum_lo[AW-1:0] : '0;
    rd_hi  = (sum_hi < SUMW'(DEPTH)) ? sum_hi[AW-1:0] : '0;
    widx   = EW'(pay_q[3].entry_index);
    wr_ok  = widx < EW'(DEPTH);
    ram_we = stg_v_q[3] && (pay_q[3].command == CMD_WRITE) && rdy[4] && wr_ok;
    ram_wdata = {pay_q[3].red_in, pay_q[3].green_in, pay_q[3].blue_in};
  end

  l3d_ram #(
    .WIDTH(ENTW),
    .DEPTH(DEPTH)
  ) u_ram_lo (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(widx[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (rdy[4]),
    .raddr_i(rd_lo),
    .rdata_o(ent_lo)
  );

  l3d_ram #(
    .WIDTH(ENTW),
    .DEPTH(DEPTH)
  ) u_ram_hi (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(widx[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (rdy[4]),
    .raddr_i(rd_hi),
    .rdata_o(ent_hi)
  );

  // blend lanes
  for (genvar g = 0; g < NCH; g++) begin : g_blend
    l3d_blend_lane #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_blend (
      .clk_i(clk_i),
      .en_i (blend_en),
      .lo_i (ent_lo[(NCH-1-g)*PIX_BITS +: PIX_BITS]),
      .hi_i (ent_hi[(NCH-1-g)*PIX_BITS +: PIX_BITS]),
      .rem_i(rem4_q[g]),
      .res_o(res_w[g])
    );
  end

  always_comb begin
    out_data_o.red_out   = res_w[0];
    out_data_o.green_out = res_w[1];
    out_data_o.blue_out  = res_w[2];
  end

`include "lut3d_color_mapper_assert.svh"

  `L3D_ASSERT_SAME(a_full_only_on_stall, !in_ready_o, out_valid_o && !out_ready_i)
  `L3D_ASSERT_NEXT(a_write_leaves_bubble, ram_we, !stg_v_q[4])
  `L3D_ASSERT_NEXT(a_ram_stage_holds, stg_v_q[4] && !rdy[4], stg_v_q[4])

endmodule
